FILE: sv/fpdot_pkg.sv
// Package: shared types, constants and the binary32 multiply and add functions.
package fpdot_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

  typedef struct packed {
    logic [31:0] elem_a;
    logic [31:0] elem_b;
    logic        last_elem;
    logic        empty_vector;
  } elem_req_t;

  typedef struct packed {
    logic [31:0] dot_value;
    logic        status;
  } dot_res_t;

  function automatic logic not_finite(input logic [31:0] u);
    not_finite = (u[30:23] == 8'hFF);
  endfunction

  function automatic logic is_nan(input logic [31:0] u);
    is_nan = (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
  endfunction

  // Round-to-nearest-even pack. mag holds the significand with the leading one at bit 26
  // (or smaller for subnormal/zero), exp is the biased exponent for bit 26, sticky in bit 0.
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [10:0] exp_in,
                                             input logic [26:0] mag_in);
    logic signed [10:0] e;
    logic [26:0] m;
    logic [4:0]  sh;
    logic        st;
    logic [24:0] rnd;
    logic [23:0] sig;
    logic        inc;
    e = exp_in;
    m = mag_in;
    if (e < 11'sd1) begin
      if ((11'sd1 - e) > 11'sd27) begin
        sh = 5'd27;
      end else begin
        sh = 5'((11'sd1 - e));
      end
      st = |(m & ((27'd1 << sh) - 27'd1));
      m = (sh >= 5'd27) ? 27'd0 : (m >> sh);
      m[0] = m[0] | st;
      e = 11'sd0;
    end
    sig = m[26:3];
    inc = m[2] && (m[1] || m[0] || sig[0]);
    rnd = {1'b0, sig} + 25'(inc);
    if (rnd[24]) begin
      e = e + 11'sd1;
      rnd = rnd >> 1;
    end else if (!rnd[23]) begin
      // no hidden bit: subnormal or zero encoding
      e = 11'sd0;
    end else if (e == 11'sd0) begin
      e = 11'sd1;
    end
    if (e >= 11'sd255) begin
      round_pack = {sgn, 8'hFF, 23'd0};
    end else begin
      round_pack = {sgn, e[7:0], rnd[22:0]};
    end
  endfunction

  // Multiply: NaN, infinity and zero cases, else normalize the 48-bit product so that the leading one sits at bit 26.
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sgn;
    logic [23:0] ma;
    logic [23:0] mb;
    logic signed [10:0] ea;
    logic signed [10:0] eb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic [47:0] pn;
    logic signed [10:0] e;
    logic [26:0] m;
    sgn = a[31] ^ b[31];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] == 8'd0) ? 11'sd1 : 11'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 11'sd1 : 11'(b[30:23]);
    lz = 6'd0;
    if (is_nan(a) || is_nan(b)) begin
      fmul = CANON_NAN;
    end else if (not_finite(a) || not_finite(b)) begin
      if ((not_finite(a) && b[30:0] == 31'd0) || (not_finite(b) && a[30:0] == 31'd0)) begin
        fmul = CANON_NAN;
      end else begin
        fmul = {sgn, 8'hFF, 23'd0};
      end
    end else begin
      p = ma * mb;
      if (p == 48'd0) begin
        fmul = {sgn, 31'd0};
      end else begin
        for (int i = 47; i >= 0; i--) begin
          if (p[i] && lz == 6'd0 && i != 47) begin
            lz = 6'(47 - i);
          end
          if (p[47]) lz = 6'd0;
        end
        for (int i = 46; i >= 0; i--) begin
          if (p[i] && (p >> (i + 1)) == 48'd0) lz = 6'(47 - i);
        end
        pn = p << lz;
        e = ea + eb - 11'sd126 - 11'(lz);
        m = {pn[47:22], |pn[21:0]};
        fmul = round_pack(sgn, e, m);
      end
    end
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [26:0] mx;
    logic [26:0] my;
    logic signed [10:0] ex;
    logic signed [10:0] ey;
    logic [7:0]  d;
    logic        st;
    logic [27:0] s;
    logic [4:0]  lz;
    logic signed [10:0] e;
    logic [26:0] m;
    lz = 5'd0;
    if (is_nan(a) || is_nan(b)) begin
      fadd = CANON_NAN;
    end else if (not_finite(a) && not_finite(b)) begin
      fadd = (a[31] != b[31]) ? CANON_NAN : a;
    end else if (not_finite(a)) begin
      fadd = a;
    end else if (not_finite(b)) begin
      fadd = b;
    end else begin
      if (a[30:0] >= b[30:0]) begin
        x = a; y = b;
      end else begin
        x = b; y = a;
      end
      mx = {(x[30:23] != 8'd0), x[22:0], 3'd0};
      my = {(y[30:23] != 8'd0), y[22:0], 3'd0};
      ex = (x[30:23] == 8'd0) ? 11'sd1 : 11'(x[30:23]);
      ey = (y[30:23] == 8'd0) ? 11'sd1 : 11'(y[30:23]);
      d = 8'(ex - ey);
      if (d > 8'd26) begin
        st = (my != 27'd0);
        my = 27'(st);
      end else begin
        st = |(my & ((27'd1 << d) - 27'd1));
        my = (my >> d) | 27'(st);
      end
      if (x[31] == y[31]) begin
        s = {1'b0, mx} + {1'b0, my};
      end else begin
        s = {1'b0, mx} - {1'b0, my};
      end
      e = ex;
      if (s == 28'd0) begin
        fadd = {(a[31] & b[31]), 31'd0};
      end else if (s[27]) begin
        m = {s[27:2], s[1] | s[0]};
        fadd = round_pack(x[31], e + 11'sd1, m);
      end else begin
        for (int i = 0; i <= 26; i++) begin
          if (s[i]) lz = 5'(26 - i);
        end
        if (11'(lz) > e - 11'sd1) lz = 5'(e - 11'sd1);
        m = 27'(s << lz);
        fadd = round_pack(x[31], e - 11'(lz), m);
      end
    end
  endfunction

endpackage

FILE: sv/fpdot_if.sv
// Interfaces: request channel for element pairs, result channel and config write channel.
interface fpdot_req_if (input logic clk);
  logic                  valid;
  logic                  ready;
  fpdot_pkg::elem_req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fpdot_res_if (input logic clk);
  logic                 valid;
  logic                 ready;
  fpdot_pkg::dot_res_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fpdot_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/fp32_dot_product_accumulator_core.sv
// Top level: streaming binary32 dot product with running sum and invalid-input checks.
// Usage:
//   req: one element pair per request (elem_a, elem_b, last_elem, empty_vector).
//   res: one result (dot_value, status) per vector, on last_elem or empty_vector.
//   cfg: write of checks_enable (reset 1); write only while the block is idle.
// Throughput: one request per cycle while res is not stalled; the product unit and the
//   adder each take one pipeline stage, so a closing request passes the product register
//   and then the result register before res goes valid.
// The whole pipeline advances together; when res is stalled with a result held,
//   req ready drops and nothing moves, not even stages that hold no result.
// Reset (rst, synchronous): running sum +0, error flag clear, checks on, pipe empty.
// The check flag is sampled by each request entering the product stage and by the
//   closing request at the adder. User must write config only while idle; not enforced.
module fp32_dot_product_accumulator_core (
  input logic         clk,
  input logic         rst,
  fpdot_req_if.sink   req,
  fpdot_res_if.source res,
  fpdot_cfg_if.sink   cfg
);
  logic        checks_enable;
  logic        adv;
  logic        m_valid;
  logic [31:0] m_prod;
  logic        m_bad;
  logic        m_last;
  logic        m_empty;

  assign adv       = !res.valid || res.ready;
  assign req.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      checks_enable <= 1'b1;
    end else if (cfg.valid) begin
      checks_enable <= cfg.data;
    end
  end

  fpdot_mul u_mul (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(req.valid), .in_req(req.payload),
    .checks(checks_enable), .valid(m_valid), .prod(m_prod), .bad(m_bad),
    .last(m_last), .empty(m_empty)
  );

  fpdot_acc u_acc (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(m_valid), .prod(m_prod), .bad(m_bad),
    .last(m_last), .empty(m_empty), .checks(checks_enable), .valid(res.valid),
    .res(res.payload)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.payload))
    else $error("result changed while stalled");
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !req.ready)
    else $error("request taken while result stalled");
  a_err_status: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload.dot_value != fpdot_pkg::CANON_NAN && res.payload.status |->
    res.payload.dot_value[30:23] == 8'hFF)
    else $error("invalid status with finite result");
endmodule

FILE: sv/fpdot_mul.sv
// Product stage: rounded binary32 product of the input pair, registered with its flags.
module fpdot_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  fpdot_pkg::elem_req_t  in_req,
  input  logic                  checks,
  output logic                  valid,
  output logic [31:0]           prod,
  output logic                  bad,
  output logic                  last,
  output logic                  empty
);
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
    if (adv) begin
      prod  <= fpdot_pkg::fmul(in_req.elem_a, in_req.elem_b);
      bad   <= checks && (fpdot_pkg::not_finite(in_req.elem_a) ||
                          fpdot_pkg::not_finite(in_req.elem_b));
      last  <= in_req.last_elem;
      empty <= in_req.empty_vector;
    end
  end
endmodule

FILE: sv/fpdot_acc.sv
// Accumulate stage: running sum, element error and the result register.
module fpdot_acc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [31:0]          prod,
  input  logic                 bad,
  input  logic                 last,
  input  logic                 empty,
  input  logic                 checks,
  output logic                 valid,
  output fpdot_pkg::dot_res_t  res
);
  logic [31:0] running_sum;
  logic        element_error;
  logic [31:0] sum_next;
  logic        err_next;
  fpdot_pkg::dot_res_t res_next;

  always_comb begin
    sum_next = running_sum;
    err_next = element_error;
    if (!element_error) begin
      if (bad) begin
        err_next = 1'b1;
      end else begin
        sum_next = fpdot_pkg::fadd(running_sum, prod);
      end
    end
    res_next.dot_value = fpdot_pkg::is_nan(sum_next) ? fpdot_pkg::CANON_NAN : sum_next;
    res_next.status    = checks && fpdot_pkg::not_finite(sum_next);
    if (err_next) begin
      res_next.dot_value = fpdot_pkg::CANON_NAN;
      res_next.status    = 1'b1;
    end
    if (empty) begin
      res_next.dot_value = fpdot_pkg::POS_ZERO;
      res_next.status    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= fpdot_pkg::POS_ZERO;
      element_error <= 1'b0;
      valid         <= 1'b0;
    end else if (adv) begin
      valid <= in_valid && (last || empty);
      if (in_valid) begin
        if (last || empty) begin
          running_sum   <= fpdot_pkg::POS_ZERO;
          element_error <= 1'b0;
        end else begin
          running_sum   <= sum_next;
          element_error <= err_next;
        end
      end
    end
    if (adv) begin
      res <= res_next;
    end
  end
endmodule
